>>> design/iou_track_association_core_defines.svh
// ---------------------------------------------------------------------------
// IoU track association assertion macros
// Shared property forms for the checker; clock and reset come from the scope.
// ---------------------------------------------------------------------------
`ifndef IOU_TRACK_ASSOCIATION_CORE_DEFINES_SVH
`define IOU_TRACK_ASSOCIATION_CORE_DEFINES_SVH

// same-cycle implication
`define IOUTA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IOUTA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/iouta_pkg.sv
// ---------------------------------------------------------------------------
// IoU track association package
// Defaults, register map, opcodes and the pipeline control bundle.
// ---------------------------------------------------------------------------
package iouta_pkg;

   localparam int unsigned ID_BITS_DEFAULT    = 8;
   localparam int unsigned COORD_BITS_DEFAULT = 12;
   localparam int unsigned BOX_BITS_DEFAULT   = 4 * COORD_BITS_DEFAULT - 2;
   localparam int unsigned DEPTH_DEFAULT      = 1 << ID_BITS_DEFAULT;

   localparam int unsigned THRESH_BITS   = 8;
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 32;

   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 8'd128;

   // register index, taken from paddr above the byte offset
   localparam logic [CSR_ADDR_BITS-3:0] REG_MATCH_THRESHOLD = '0;

   localparam logic OP_DETECT    = 1'b0;
   localparam logic OP_FRAME_END = 1'b1;

   typedef struct packed {
      logic clear;   // reset the running best before a walk
      logic sample;  // entry on the input is a valid track
   } iouta_ctl_type;

endpackage

>>> design/iouta_ram.sv
// ---------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module iouta_ram #(
   parameter int unsigned WIDTH = iouta_pkg::BOX_BITS_DEFAULT,
   parameter int unsigned DEPTH = iouta_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> design/iouta_regs.sv
// ---------------------------------------------------------------------------
// IoU track association control registers
// APB-style access to the match threshold.
// ---------------------------------------------------------------------------
module iouta_regs (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [iouta_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [iouta_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [iouta_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output logic [iouta_pkg::THRESH_BITS-1:0]     threshold
);

   logic [iouta_pkg::THRESH_BITS-1:0] thr_ff;
   logic [iouta_pkg::THRESH_BITS-1:0] thr_in;
   logic                              hit;

   assign hit        = csr_paddr[iouta_pkg::CSR_ADDR_BITS-1:2] == iouta_pkg::REG_MATCH_THRESHOLD;
   assign csr_pready = 1'b1;
   assign threshold  = thr_ff;

   always_comb begin
      thr_in = thr_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         thr_in = csr_pwdata[iouta_pkg::THRESH_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (hit) begin
         csr_prdata[iouta_pkg::THRESH_BITS-1:0] = thr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= iouta_pkg::THRESH_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

endmodule

>>> design/iouta_iou_unit.sv
// ---------------------------------------------------------------------------
// IoU compare unit
// Pipelined intersection/union of one track against the detection per cycle,
// with an exact cross-multiplied running best.
// ---------------------------------------------------------------------------
module iouta_iou_unit #(
   parameter int unsigned ID_BITS    = iouta_pkg::ID_BITS_DEFAULT,
   parameter int unsigned COORD_BITS = iouta_pkg::COORD_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  iouta_pkg::iouta_ctl_type  ctl,
   input  logic [ID_BITS-1:0]        trk_id,
   input  logic [4*COORD_BITS-3:0]   trk_box,
   input  logic [4*COORD_BITS-3:0]   det_box,
   output logic                      busy,
   output logic                      found,
   output logic [ID_BITS-1:0]        best_id,
   output logic [2*COORD_BITS-3:0]   best_inter,
   output logic [2*COORD_BITS-2:0]   best_union
);

   localparam int unsigned C         = COORD_BITS;
   localparam int unsigned SIZE_BITS = COORD_BITS - 1;
   localparam int unsigned AREA_BITS = 2 * COORD_BITS - 2;
   localparam int unsigned UNI_BITS  = 2 * COORD_BITS - 1;
   localparam int unsigned PROD_BITS = 4 * COORD_BITS - 3;

   function automatic logic [SIZE_BITS-1:0] overlap(
      input logic signed [C-1:0] a0,
      input logic [SIZE_BITS-1:0] al,
      input logic signed [C-1:0] b0,
      input logic [SIZE_BITS-1:0] bl
   );
      logic signed [C:0]   a_end;
      logic signed [C:0]   b_end;
      logic signed [C:0]   lo;
      logic signed [C:0]   hi;
      logic signed [C+1:0] span;
      a_end = $signed({a0[C-1], a0}) + $signed({2'b00, al});
      b_end = $signed({b0[C-1], b0}) + $signed({2'b00, bl});
      hi    = (a_end < b_end) ? a_end : b_end;
      lo    = (a0 > b0) ? $signed({a0[C-1], a0}) : $signed({b0[C-1], b0});
      span  = $signed({hi[C], hi}) - $signed({lo[C], lo});
      // overlap never exceeds either size, so the low bits hold it
      overlap = (span > 0) ? span[SIZE_BITS-1:0] : '0;
   endfunction

   logic signed [C-1:0]   tl, tt, dl, dt;
   logic [SIZE_BITS-1:0]  tw, th, dw, dh;

   assign tl = trk_box[4*C-3 -: C];
   assign tt = trk_box[3*C-3 -: C];
   assign tw = trk_box[2*C-3 -: SIZE_BITS];
   assign th = trk_box[SIZE_BITS-1:0];
   assign dl = det_box[4*C-3 -: C];
   assign dt = det_box[3*C-3 -: C];
   assign dw = det_box[2*C-3 -: SIZE_BITS];
   assign dh = det_box[SIZE_BITS-1:0];

   // stage 1: overlap lengths, track area and detection area
   logic                 v1_ff;
   logic [ID_BITS-1:0]   id1_ff;
   logic [SIZE_BITS-1:0] iw1_ff, ih1_ff;
   logic [AREA_BITS-1:0] area1_ff;
   logic [AREA_BITS-1:0] det_area_ff;
   // stage 2: intersection area
   logic                 v2_ff;
   logic [ID_BITS-1:0]   id2_ff;
   logic [AREA_BITS-1:0] ia2_ff, area2_ff;
   // stage 3: union
   logic                 v3_ff;
   logic [ID_BITS-1:0]   id3_ff;
   logic [AREA_BITS-1:0] inter3_ff;
   logic [UNI_BITS-1:0]  uni3_ff;
   // running best
   logic                 found_ff, found_in;
   logic [ID_BITS-1:0]   best_id_ff, best_id_in;
   logic [AREA_BITS-1:0] best_i_ff, best_i_in;
   logic [UNI_BITS-1:0]  best_u_ff, best_u_in;
   logic [PROD_BITS-1:0] lhs, rhs;

   assign lhs = PROD_BITS'(inter3_ff) * PROD_BITS'(best_u_ff);
   assign rhs = PROD_BITS'(best_i_ff) * PROD_BITS'(uni3_ff);

   always_comb begin
      found_in   = found_ff;
      best_id_in = best_id_ff;
      best_i_in  = best_i_ff;
      best_u_in  = best_u_ff;
      priority if (ctl.clear) begin
         found_in  = 1'b0;
         best_i_in = '0;
         best_u_in = UNI_BITS'(1);
      end else if (v3_ff && (lhs > rhs)) begin
         found_in   = 1'b1;
         best_id_in = id3_ff;
         best_i_in  = inter3_ff;
         best_u_in  = uni3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         v1_ff    <= ctl.sample;
         v2_ff    <= v1_ff;
         // zero intersection never wins, empty union implies it
         v3_ff    <= v2_ff && (ia2_ff != '0);
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      id1_ff      <= trk_id;
      iw1_ff      <= overlap(tl, tw, dl, dw);
      ih1_ff      <= overlap(tt, th, dt, dh);
      area1_ff    <= AREA_BITS'(tw) * AREA_BITS'(th);
      det_area_ff <= AREA_BITS'(dw) * AREA_BITS'(dh);
      id2_ff      <= id1_ff;
      ia2_ff      <= AREA_BITS'(iw1_ff) * AREA_BITS'(ih1_ff);
      area2_ff    <= area1_ff;
      id3_ff      <= id2_ff;
      inter3_ff   <= ia2_ff;
      uni3_ff     <= {1'b0, area2_ff} + {1'b0, det_area_ff} - {1'b0, ia2_ff};
      best_id_ff  <= best_id_in;
      best_i_ff   <= best_i_in;
      best_u_ff   <= best_u_in;
   end

   assign busy       = v1_ff || v2_ff || v3_ff;
   assign found      = found_ff;
   assign best_id    = best_id_ff;
   assign best_inter = best_i_ff;
   assign best_union = best_u_ff;

endmodule

>>> design/iou_track_association_core.sv
// ---------------------------------------------------------------------------
// IoU track association core
// Greedy IoU matching of detections against a ping-pong track table.
// ---------------------------------------------------------------------------
// The sequencer reads every entry of the current track memory, one per cycle,
// through the single pipelined IoU compare unit, and waits until the unit
// drains. The drain is longest when the last entries read are valid and
// overlap the detection. It then passes through the threshold test, the table
// write and delivery. An end-of-frame beat goes from accept straight to
// delivery. The tables swap by flipping a bank bit and clearing the flip-flop
// valid bits, so no clearing pass runs after reset. req_stall is high while an
// item is in progress, and a stalled result holds the sequencer in delivery.
module iou_track_association_core #(
   parameter int unsigned ID_BITS    = iouta_pkg::ID_BITS_DEFAULT,
   parameter int unsigned COORD_BITS = iouta_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic signed [COORD_BITS-1:0]        req_box_left,
   input  logic signed [COORD_BITS-1:0]        req_box_top,
   input  logic [COORD_BITS-2:0]               req_box_width,
   input  logic [COORD_BITS-2:0]               req_box_height,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ID_BITS-1:0]                  rsp_track_id,
   output logic                                rsp_matched,
   output logic                                rsp_frame_end,
   output logic [ID_BITS:0]                    rsp_track_count,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [iouta_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [iouta_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [iouta_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                csr_pready
);

   localparam int unsigned NUM_IDS   = 1 << ID_BITS;
   localparam int unsigned BOX_BITS  = 4 * COORD_BITS - 2;
   localparam int unsigned AREA_BITS = 2 * COORD_BITS - 2;
   localparam int unsigned UNI_BITS  = 2 * COORD_BITS - 1;
   localparam int unsigned CMP_BITS  = UNI_BITS + iouta_pkg::THRESH_BITS;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_WALK    = 3'd1;
   localparam logic [2:0] ST_DECIDE  = 3'd2;
   localparam logic [2:0] ST_COMMIT  = 3'd3;
   localparam logic [2:0] ST_DELIVER = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic                bank_ff, bank_in;
   logic [NUM_IDS-1:0]  valid0_ff, valid0_in, valid1_ff, valid1_in;
   logic [NUM_IDS-1:0]  cur_valid, nxt_valid;
   logic [ID_BITS-1:0]  next_id_ff, next_id_in;
   logic [ID_BITS:0]    next_count_ff, next_count_in;
   logic [ID_BITS:0]    cnt_ff, cnt_in;
   logic                rd_v_ff, rd_v_in;
   logic [ID_BITS-1:0]  rd_id_ff, rd_id_in;
   logic [BOX_BITS-1:0] det_box_ff, det_box_in;
   logic                matched_ff, matched_in;
   logic [ID_BITS-1:0]  res_id_ff, res_id_in;
   logic                res_matched_ff, res_matched_in;
   logic                res_frame_end_ff, res_frame_end_in;
   logic [ID_BITS:0]    res_count_ff, res_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0]  rsp_id_ff, rsp_id_in;
   logic                rsp_matched_ff, rsp_matched_in;
   logic                rsp_frame_end_ff, rsp_frame_end_in;
   logic [ID_BITS:0]    rsp_count_ff, rsp_count_in;

   logic                          wr_en, rd_en;
   logic [ID_BITS-1:0]            commit_id;
   logic [BOX_BITS-1:0]           rd_data0, rd_data1, trk_box;
   iouta_pkg::iouta_ctl_type      ctl;
   logic                          busy, found;
   logic [ID_BITS-1:0]            best_id;
   logic [AREA_BITS-1:0]          best_inter;
   logic [UNI_BITS-1:0]           best_union;
   logic [iouta_pkg::THRESH_BITS-1:0] threshold;
   logic [CMP_BITS-1:0]           thr_prod, inter_scaled;

   iouta_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .threshold   (threshold)
   );

   // bank 0 is next while bank_ff is 1, and the other way round
   iouta_ram #(.WIDTH(BOX_BITS), .DEPTH(NUM_IDS)) u_ram0 (
      .clock   (clock),
      .wr_en   (wr_en && bank_ff),
      .wr_addr (commit_id),
      .wr_data (det_box_ff),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[ID_BITS-1:0]),
      .rd_data (rd_data0)
   );

   iouta_ram #(.WIDTH(BOX_BITS), .DEPTH(NUM_IDS)) u_ram1 (
      .clock   (clock),
      .wr_en   (wr_en && !bank_ff),
      .wr_addr (commit_id),
      .wr_data (det_box_ff),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[ID_BITS-1:0]),
      .rd_data (rd_data1)
   );

   assign trk_box = bank_ff ? rd_data1 : rd_data0;

   iouta_iou_unit #(.ID_BITS(ID_BITS), .COORD_BITS(COORD_BITS)) u_iou (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .trk_id     (rd_id_ff),
      .trk_box    (trk_box),
      .det_box    (det_box_ff),
      .busy       (busy),
      .found      (found),
      .best_id    (best_id),
      .best_inter (best_inter),
      .best_union (best_union)
   );

   assign cur_valid    = bank_ff ? valid1_ff : valid0_ff;
   assign nxt_valid    = bank_ff ? valid0_ff : valid1_ff;
   assign commit_id    = matched_ff ? best_id : next_id_ff;
   assign thr_prod     = CMP_BITS'(threshold) * CMP_BITS'(best_union);
   assign inter_scaled = CMP_BITS'({best_inter, iouta_pkg::THRESH_BITS'(0)});
   assign rd_en        = (state_ff == ST_WALK) && !cnt_ff[ID_BITS];

   always_comb begin
      state_in         = state_ff;
      bank_in          = bank_ff;
      valid0_in        = valid0_ff;
      valid1_in        = valid1_ff;
      next_id_in       = next_id_ff;
      next_count_in    = next_count_ff;
      cnt_in           = cnt_ff;
      rd_v_in          = 1'b0;
      rd_id_in         = rd_id_ff;
      det_box_in       = det_box_ff;
      matched_in       = matched_ff;
      res_id_in        = res_id_ff;
      res_matched_in   = res_matched_ff;
      res_frame_end_in = res_frame_end_ff;
      res_count_in     = res_count_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_id_in        = rsp_id_ff;
      rsp_matched_in   = rsp_matched_ff;
      rsp_frame_end_in = rsp_frame_end_ff;
      rsp_count_in     = rsp_count_ff;
      wr_en            = 1'b0;
      ctl.clear        = 1'b0;
      ctl.sample       = rd_v_ff && cur_valid[rd_id_ff];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == iouta_pkg::OP_FRAME_END) begin
                  res_id_in        = '0;
                  res_matched_in   = 1'b0;
                  res_frame_end_in = 1'b1;
                  res_count_in     = next_count_ff;
                  // swap tables and empty the one that becomes next
                  bank_in          = !bank_ff;
                  if (bank_ff) begin
                     valid1_in = '0;
                  end else begin
                     valid0_in = '0;
                  end
                  next_count_in = '0;
                  state_in      = ST_DELIVER;
               end else begin
                  det_box_in = {req_box_left, req_box_top, req_box_width, req_box_height};
                  cnt_in     = '0;
                  ctl.clear  = 1'b1;
                  state_in   = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (!cnt_ff[ID_BITS]) begin
               rd_v_in  = 1'b1;
               rd_id_in = cnt_ff[ID_BITS-1:0];
               cnt_in   = cnt_ff + 1'b1;
            end else if (!rd_v_ff && !busy) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            matched_in = found && (inter_scaled > thr_prod);
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            wr_en = 1'b1;
            if (!matched_ff) begin
               next_id_in = next_id_ff + 1'b1;
            end
            if (!nxt_valid[commit_id]) begin
               next_count_in = next_count_ff + 1'b1;
            end
            if (bank_ff) begin
               valid0_in[commit_id] = 1'b1;
            end else begin
               valid1_in[commit_id] = 1'b1;
            end
            res_id_in        = commit_id;
            res_matched_in   = matched_ff;
            res_frame_end_in = 1'b0;
            res_count_in     = '0;
            state_in         = ST_DELIVER;
         end
         ST_DELIVER: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_id_in        = res_id_ff;
               rsp_matched_in   = res_matched_ff;
               rsp_frame_end_in = res_frame_end_ff;
               rsp_count_in     = res_count_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bank_ff       <= 1'b0;
         valid0_ff     <= '0;
         valid1_ff     <= '0;
         next_id_ff    <= '0;
         next_count_ff <= '0;
         cnt_ff        <= '0;
         rd_v_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bank_ff       <= bank_in;
         valid0_ff     <= valid0_in;
         valid1_ff     <= valid1_in;
         next_id_ff    <= next_id_in;
         next_count_ff <= next_count_in;
         cnt_ff        <= cnt_in;
         rd_v_ff       <= rd_v_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_id_ff         <= rd_id_in;
      det_box_ff       <= det_box_in;
      matched_ff       <= matched_in;
      res_id_ff        <= res_id_in;
      res_matched_ff   <= res_matched_in;
      res_frame_end_ff <= res_frame_end_in;
      res_count_ff     <= res_count_in;
      rsp_id_ff        <= rsp_id_in;
      rsp_matched_ff   <= rsp_matched_in;
      rsp_frame_end_ff <= rsp_frame_end_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign req_stall       = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_track_id    = rsp_id_ff;
   assign rsp_matched     = rsp_matched_ff;
   assign rsp_frame_end   = rsp_frame_end_ff;
   assign rsp_track_count = rsp_count_ff;

endmodule

>>> design/iouta_checker.sv
// ---------------------------------------------------------------------------
// IoU track association port checker
// Temporal checks on the top-level ports, bound to the core.
// ---------------------------------------------------------------------------
`include "iou_track_association_core_defines.svh"

module iouta_checker #(
   parameter int unsigned ID_BITS    = iouta_pkg::ID_BITS_DEFAULT,
   parameter int unsigned COORD_BITS = iouta_pkg::COORD_BITS_DEFAULT
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_opcode,
   input logic signed [COORD_BITS-1:0]        req_box_left,
   input logic signed [COORD_BITS-1:0]        req_box_top,
   input logic [COORD_BITS-2:0]               req_box_width,
   input logic [COORD_BITS-2:0]               req_box_height,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [ID_BITS-1:0]                  rsp_track_id,
   input logic                                rsp_matched,
   input logic                                rsp_frame_end,
   input logic [ID_BITS:0]                    rsp_track_count,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [iouta_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [iouta_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input logic [iouta_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   input logic                                csr_pready
);

   // one item at a time: a new beat closes the input side
   `IOUTA_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "input open after accept")

   `IOUTA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_track_id), "result dropped")

   `IOUTA_ASSERT_SAME(a_frame_end_fields, rsp_valid && rsp_frame_end, (rsp_track_id == '0) && !rsp_matched, "frame end with id")

   `IOUTA_ASSERT_SAME(a_detect_count, rsp_valid && !rsp_frame_end, rsp_track_count == '0, "detection with count")

endmodule

bind iou_track_association_core iouta_checker #(
   .ID_BITS    (ID_BITS),
   .COORD_BITS (COORD_BITS)
) u_checker (.*);
